/* design/ths_pkg.sv */
// Shared constants, types and edge tables of the hyperplane slicer.
`default_nettype none
package ths_pkg;

  localparam int VERTEX_DEPTH = 1024;
  localparam int COORD_W      = 32;
  localparam int MAG_W        = 50;   // |distance| < 2^49
  localparam int ACC_W        = 51;   // signed distance accumulator
  localparam int NUM_W        = 84;   // signed interpolation numerator
  localparam int IDX_EXT_W    = 17;   // holds any depth up to 65536

  localparam logic [2:0] REG_NORMAL_X     = 3'd0;
  localparam logic [2:0] REG_NORMAL_Y     = 3'd1;
  localparam logic [2:0] REG_NORMAL_Z     = 3'd2;
  localparam logic [2:0] REG_NORMAL_W     = 3'd3;
  localparam logic [2:0] REG_PLANE_OFFSET = 3'd4;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_CORNER = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] w;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } corner_t;

  localparam int CORNER_W = $bits(corner_t);
  localparam int VERTEX_W = 4 * COORD_W;

  function automatic logic [2:0] edge_cnt(input logic [3:0] row);
    logic [2:0] n;
    unique case (row)
      4'd0, 4'd15:                                  n = 3'd0;
      4'd3, 4'd5, 4'd6, 4'd9, 4'd10, 4'd12:         n = 3'd4;
      default:                                      n = 3'd3;
    endcase
    return n;
  endfunction

  // {a, b} of crossed edge e of a row, two bits each
  function automatic logic [3:0] edge_pair(input logic [3:0] row, input logic [1:0] e);
    logic [15:0] tab;
    unique case (row)
      4'd1, 4'd14: tab = 16'hCDE0;
      4'd2, 4'd13: tab = 16'h89B0;
      4'd3, 4'd12: tab = 16'h2367;
      4'd4, 4'd11: tab = 16'h4670;
      4'd5, 4'd10: tab = 16'h136B;
      4'd6, 4'd9:  tab = 16'h127B;
      4'd7, 4'd8:  tab = 16'h1230;
      default:     tab = 16'h0000;
    endcase
    return 4'(tab >> (4 * (3 - int'(e))));
  endfunction

  // emission order of a four-point cut: p0 p1 p2 p1 p2 p3
  function automatic logic [1:0] order4(input logic [2:0] j);
    logic [1:0] p;
    unique case (j)
      3'd0:       p = 2'd0;
      3'd1, 3'd3: p = 2'd1;
      3'd2, 3'd4: p = 2'd2;
      default:    p = 2'd3;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

/* design/ths_in_if.sv */
// Input item channel of the hyperplane slicer.
`default_nettype none
interface ths_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [9:0]         vertex_index;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic signed [31:0] coord_w;

  modport source (output valid, func, vertex_index, coord_x, coord_y, coord_z, coord_w,
                  input ready);
  modport sink   (input valid, func, vertex_index, coord_x, coord_y, coord_z, coord_w,
                  output ready);
endinterface
`default_nettype wire

/* design/ths_out_if.sv */
// Output point channel of the hyperplane slicer.
`default_nettype none
interface ths_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic               run_last;

  modport source (output valid, point_x, point_y, point_z, run_last, input ready);
  modport sink   (input valid, point_x, point_y, point_z, run_last, output ready);
endinterface
`default_nettype wire

/* design/tetrahedron_hyperplane_slicer_unit.sv */
// Top level: vertex store, corner buffer, distance and interpolation sequencer.
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+-----------------------------------------------
//  item_in   | in  | valid/ready   | func, vertex_index, coord_x..coord_w
//  point_out | out | valid/ready   | point_x, point_y, point_z, run_last
//  wr_*      | in  | wr_en only    | wr_index (3b), wr_data (32b)
//
// A corner item passes a vertex read and a corner buffer write. The fourth corner then
// adds a distance pass for each of the 4 corners (buffer read, 5 dot-product steps on
// one 32x32 multiplier, save), a row lookup and, per emitted point, the reads of the
// edge's two corners, then per coordinate a multiply-accumulate, a radix-2 division and
// a store, and an emit step. Synchronous reset clears control and the normal and offset
// registers; the memories need no clearing. A stalled output holds the point, and the
// next item is taken while the last point of a tetrahedron waits.
`default_nettype none
module tetrahedron_hyperplane_slicer_unit
  import ths_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  ths_in_if.sink           item_in,
  ths_out_if.source        point_out,
  input  wire logic        wr_en,
  input  wire logic [2:0]  wr_index,
  input  wire logic [31:0] wr_data
);
  localparam int VA_W = $clog2(VERTEX_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_CWR, S_DRD, S_DIST, S_DSAVE, S_ROW, S_RA, S_RB, S_LB, S_MUL, S_DIV,
    S_PUT, S_EMIT
  } state_t;

  state_t state;

  logic signed [31:0] nrm [4];
  logic signed [31:0] plane_offset;

  // vertex store
  logic [IDX_EXT_W-1:0] idx_ext;
  logic                 in_range;
  logic                 accept;
  logic                 v_we, v_re;
  logic [VERTEX_W-1:0]  v_rdata;
  logic                 oor;

  assign accept   = item_in.valid && item_in.ready;
  assign idx_ext  = IDX_EXT_W'(item_in.vertex_index);
  assign in_range = idx_ext < IDX_EXT_W'(VERTEX_DEPTH);
  assign v_we     = accept && (item_in.func == FUNC_WRITE) && in_range;
  assign v_re     = accept && (item_in.func == FUNC_CORNER);
  assign item_in.ready = (state == S_IDLE);

  ths_ram #(.WIDTH(VERTEX_W), .DEPTH(VERTEX_DEPTH)) u_vstore (
    .clk   (clk),
    .we    (v_we),
    .waddr (idx_ext[VA_W-1:0]),
    .wdata ({item_in.coord_w, item_in.coord_z, item_in.coord_y, item_in.coord_x}),
    .re    (v_re),
    .raddr (idx_ext[VA_W-1:0]),
    .rdata (v_rdata)
  );

  logic [VERTEX_W-1:0] vtx;
  assign vtx = oor ? '0 : v_rdata;

  // corner buffer
  corner_t             c_rdata_s;
  logic [CORNER_W-1:0] c_rdata;
  logic                c_re;
  logic [1:0]          c_raddr;
  logic [1:0]          ccount;
  logic [1:0]          dcorner;
  logic [3:0]          above;
  logic [2:0]          nedge, outn, jout;
  logic [1:0]          esel, ea, eb;

  assign nedge = edge_cnt(above);
  assign outn  = (nedge == 3'd4) ? 3'd6 : nedge;
  assign esel  = (nedge == 3'd4) ? order4(jout) : jout[1:0];
  assign {ea, eb} = edge_pair(above, esel);
  assign c_re    = (state == S_DRD) || (state == S_RA) || (state == S_RB);
  assign c_raddr = (state == S_DRD) ? dcorner : ((state == S_RA) ? ea : eb);
  assign c_rdata_s = corner_t'(c_rdata);

  ths_ram #(.WIDTH(CORNER_W), .DEPTH(4)) u_cbuf (
    .clk   (clk),
    .we    (state == S_CWR),
    .waddr (ccount),
    .wdata (vtx),
    .re    (c_re),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  // distance datapath
  logic [2:0]              dstep;
  logic signed [63:0]      dprod;
  logic signed [ACC_W-1:0] dacc;
  logic signed [31:0]      dcoord;
  logic [MAG_W-1:0]        dmag;
  logic [MAG_W-1:0]        mag_r [4];
  logic [MAG_W-1:0]        ma, mb;

  assign dcoord = c_rdata[32*dstep[1:0] +: 32];
  assign dmag   = dacc[ACC_W-1] ? MAG_W'(-dacc) : MAG_W'(dacc);
  assign ma     = mag_r[ea];
  assign mb     = mag_r[eb];

  // interpolation datapath
  corner_t                 ca, cb;
  logic [ACC_W-1:0]        den;
  logic [1:0]              kc;
  logic [2:0]              mstep;
  logic signed [57:0]      mprod;
  logic signed [NUM_W-1:0] num;
  logic signed [31:0]      opv, va, vb;
  logic [24:0]             opm;
  logic [5:0]              dcnt;
  logic                    qneg;
  logic [ACC_W-1:0]        rem;
  logic [31:0]             qsh;
  logic [NUM_W-1:0]        nabs;
  logic [ACC_W:0]          r2;
  logic                    ge;
  logic signed [31:0]      pt [3];

  always_comb begin
    unique case (kc)
      2'd0:    begin va = ca.x; vb = cb.x; end
      2'd1:    begin va = ca.y; vb = cb.y; end
      default: begin va = ca.z; vb = cb.z; end
    endcase
    unique case (mstep[1:0])
      2'd0:    begin opv = va; opm = mb[24:0]; end
      2'd1:    begin opv = va; opm = mb[49:25]; end
      2'd2:    begin opv = vb; opm = ma[24:0]; end
      default: begin opv = vb; opm = ma[49:25]; end
    endcase
  end

  assign nabs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign r2   = {rem, qsh[31]};
  assign ge   = r2 >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      ccount          <= '0;
      point_out.valid <= 1'b0;
      nrm[0]          <= '0;
      nrm[1]          <= '0;
      nrm[2]          <= '0;
      nrm[3]          <= '0;
      plane_offset    <= '0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_NORMAL_X:     nrm[0] <= wr_data;
          REG_NORMAL_Y:     nrm[1] <= wr_data;
          REG_NORMAL_Z:     nrm[2] <= wr_data;
          REG_NORMAL_W:     nrm[3] <= wr_data;
          REG_PLANE_OFFSET: plane_offset <= wr_data;
          default: ;
        endcase
      end
      if (point_out.ready && (state != S_EMIT)) begin
        point_out.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (v_re) begin
            oor   <= !in_range;
            state <= S_CWR;
          end
        end
        S_CWR: begin
          ccount  <= ccount + 2'd1;
          dcorner <= '0;
          state   <= (ccount == 2'd3) ? S_DRD : S_IDLE;
        end
        S_DRD: begin
          dstep <= '0;
          dacc  <= ACC_W'(plane_offset);
          state <= S_DIST;
        end
        S_DIST: begin
          if (dstep < 3'd4) begin
            dprod <= dcoord * nrm[dstep[1:0]];
          end
          if (dstep != 3'd0) begin
            dacc <= dacc + ACC_W'(dprod >>> 16);
          end
          dstep <= dstep + 3'd1;
          if (dstep == 3'd4) begin
            state <= S_DSAVE;
          end
        end
        S_DSAVE: begin
          mag_r[dcorner]        <= dmag;
          above[2'd3 - dcorner] <= (dacc > 0);
          dcorner <= dcorner + 2'd1;
          state   <= (dcorner == 2'd3) ? S_ROW : S_DRD;
        end
        S_ROW: begin
          jout  <= '0;
          state <= (nedge == 3'd0) ? S_IDLE : S_RA;
        end
        S_RA: state <= S_RB;
        S_RB: begin
          ca    <= c_rdata_s;
          state <= S_LB;
        end
        S_LB: begin
          cb    <= c_rdata_s;
          den   <= ACC_W'(ma) + ACC_W'(mb);
          kc    <= '0;
          mstep <= '0;
          num   <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          if (mstep < 3'd4) begin
            mprod <= opv * $signed({1'b0, opm});
          end
          if (mstep != 3'd0) begin
            // even steps carry the upper half of the magnitude
            num <= num + (mstep[0] ? NUM_W'(mprod) : (NUM_W'(mprod) <<< 25));
          end
          mstep <= mstep + 3'd1;
          if (mstep == 3'd4) begin
            dcnt  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (dcnt == 6'd0) begin
            qneg <= num[NUM_W-1];
            rem  <= ACC_W'(nabs >> 32);
            qsh  <= nabs[31:0];
          end else begin
            rem <= ge ? ACC_W'(r2 - {1'b0, den}) : r2[ACC_W-1:0];
            qsh <= {qsh[30:0], ge};
          end
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd32) begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          pt[kc] <= qneg ? -qsh : qsh;
          kc     <= kc + 2'd1;
          mstep  <= '0;
          num    <= '0;
          state  <= (kc == 2'd2) ? S_EMIT : S_MUL;
        end
        S_EMIT: begin
          if (!point_out.valid || point_out.ready) begin
            point_out.valid    <= 1'b1;
            point_out.point_x  <= pt[0];
            point_out.point_y  <= pt[1];
            point_out.point_z  <= pt[2];
            point_out.run_last <= (jout == outn - 3'd1);
            jout  <= jout + 3'd1;
            state <= (jout == outn - 3'd1) ? S_IDLE : S_RA;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // remainder of the divider stays below the denominator
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && dcnt != 6'd0) |-> (rem < den))
    else $error("divider remainder out of range");

  // a point is only presented from the emit state
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(point_out.valid) |-> $past(state) == S_EMIT)
    else $error("point presented outside emit");

  // a distance is saved only after the full dot-product sequence
  a_dsave_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_DSAVE) |-> ($past(state) == S_DIST && $past(dstep) == 3'd4))
    else $error("distance saved out of order");

endmodule
`default_nettype wire

/* design/ths_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module ths_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire
